// ===== hw/rtl/partially_mapped_crossover_top_defines.svh =====
// Assertion macros shared by the crossover RTL.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef PARTIALLY_MAPPED_CROSSOVER_TOP_DEFINES_SVH
`define PARTIALLY_MAPPED_CROSSOVER_TOP_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define PMX_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define PMX_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/pmx_pkg.sv =====
// Shared widths, register map and control structs for the crossover block.
// No dependencies; compiled before every other RTL file.
package pmx_pkg;

   localparam int TOWN_W        = 6;
   localparam int POS_W         = 6;
   localparam int LEN_W         = 7;
   localparam int TOWN_CNT      = 64;
   localparam int DEF_MAX_TOWNS = 64;

   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] REG_TOUR_LENGTH = 1'b0;
   localparam logic [LEN_W-1:0]      TOUR_LENGTH_RST = 7'd64;

   // Top level to chain unit
   typedef struct packed {
      logic              load_en;
      logic [POS_W-1:0]  load_pos;
      logic [TOWN_W-1:0] load_town;
      logic              map_clear;
      logic              map_en;
      logic [TOWN_W-1:0] map_town;
      logic [POS_W-1:0]  map_pos;
      logic [POS_W-1:0]  rd_pos;
      logic              walk_start;
      logic [TOWN_W-1:0] walk_town;
      logic [LEN_W-1:0]  walk_len;
   } chain_cmd_type;

   // Chain unit to top level
   typedef struct packed {
      logic [TOWN_W-1:0] rd_town;
      logic              done;
      logic [TOWN_W-1:0] town;
      logic              err;
   } chain_sts_type;

endpackage

// ===== hw/rtl/pmx_req_if.sv =====
// Load transaction channel: one position of both parents plus cut points.
// Depends on pmx_pkg.
interface pmx_req_if;
   import pmx_pkg::*;

   logic              valid;
   logic              ready;
   logic [TOWN_W-1:0] parent_a_town;
   logic [TOWN_W-1:0] parent_b_town;
   logic [POS_W-1:0]  cut_first;
   logic [POS_W-1:0]  cut_second;

   modport source (output valid, parent_a_town, parent_b_town, cut_first, cut_second,
                   input ready);
   modport sink   (input valid, parent_a_town, parent_b_town, cut_first, cut_second,
                   output ready);
endinterface

// ===== hw/rtl/pmx_rsp_if.sv =====
// Result transaction channel: one child position of both children.
// Depends on pmx_pkg.
interface pmx_rsp_if;
   import pmx_pkg::*;

   logic              valid;
   logic              ready;
   logic [POS_W-1:0]  child_position;
   logic [TOWN_W-1:0] child_a_town;
   logic [TOWN_W-1:0] child_b_town;
   logic              chain_error;
   logic              last_of_tour;

   modport source (output valid, child_position, child_a_town, child_b_town,
                   chain_error, last_of_tour, input ready);
   modport sink   (input valid, child_position, child_a_town, child_b_town,
                   chain_error, last_of_tour, output ready);
endinterface

// ===== hw/rtl/partially_mapped_crossover_top.sv =====
// Partially mapped crossover (PMX) of two town permutations. Load transactions
// arrive one per cycle while loading, each writing the towns of both parents
// at the next position; the transaction at position tour_length-1 (tour_length
// saturated to [2, MAX_TOWNS]) also samples the cut points, which saturate to
// length-1 and are put in order. The block then sweeps the segment from its
// high end down, reading both parents, then writing both maps at each position,
// building for each parent a map from town to lowest segment position. After
// that it returns one result transaction per position: inside the segment the
// towns are swapped, outside it the result waits for both chains; each chain
// step is one map read and one parent read, each a registered memory read.
// A chain that is still going after tour_length replacements stops and raises
// chain_error. No load transaction is taken from the last load until the last
// result has been handed to the output register.
// Depends on pmx_pkg, pmx_req_if, pmx_rsp_if, pmx_chain and the defines header.
module partially_mapped_crossover_top #(
   parameter int MAX_TOWNS = pmx_pkg::DEF_MAX_TOWNS
) (
   input  logic                           clock,
   input  logic                           reset,
   pmx_req_if.sink                        req_chan,
   pmx_rsp_if.source                      rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pmx_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pmx_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [pmx_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import pmx_pkg::*;

   `include "partially_mapped_crossover_top_defines.svh"

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_TOWNS);
   localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(2);

   // sequencer codes
   localparam logic [2:0] S_LOAD   = 3'd0;  // taking load transactions
   localparam logic [2:0] S_BREAD  = 3'd1;  // map build: read parents at k
   localparam logic [2:0] S_BWRITE = 3'd2;  // map build: write both maps
   localparam logic [2:0] S_EREAD  = 3'd3;  // emit: read parents at i
   localparam logic [2:0] S_EDEC   = 3'd4;  // emit: swap or start chains
   localparam logic [2:0] S_WALK   = 3'd5;  // emit: chains running
   localparam logic [2:0] S_OUT    = 3'd6;  // emit: hand result to output reg

   // ---------------- configuration register ----------------
   logic [LEN_W-1:0] tour_length_ff, tour_length_in;
   logic             csr_write;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_TOUR_LENGTH) ? CSR_DATA_W'(tour_length_ff) : '0;

   always_comb begin
      tour_length_in = tour_length_ff;
      if (csr_write && (csr_paddr == REG_TOUR_LENGTH)) begin
         tour_length_in = csr_pwdata[LEN_W-1:0];
      end
   end

   // ---------------- effective length and cuts ----------------
   logic [LEN_W-1:0] len_eff;
   logic [LEN_W-1:0] last_m1;
   logic [POS_W-1:0] cut_a, cut_b, cut_lo, cut_hi;

   always_comb begin
      if (tour_length_ff < MIN_LEN) begin
         len_eff = MIN_LEN;
      end else if (tour_length_ff > MAX_LEN) begin
         len_eff = MAX_LEN;
      end else begin
         len_eff = tour_length_ff;
      end
   end

   assign last_m1 = len_eff - 1'b1;
   assign cut_a   = ({1'b0, req_chan.cut_first} > last_m1)  ? last_m1[POS_W-1:0]
                                                            : req_chan.cut_first;
   assign cut_b   = ({1'b0, req_chan.cut_second} > last_m1) ? last_m1[POS_W-1:0]
                                                            : req_chan.cut_second;
   assign cut_lo  = (cut_a > cut_b) ? cut_b : cut_a;
   assign cut_hi  = (cut_a > cut_b) ? cut_a : cut_b;

   // ---------------- sequencer state ----------------
   logic [2:0]        state_ff, state_in;
   logic [LEN_W-1:0]  load_count_ff, load_count_in;
   logic [POS_W-1:0]  seg_low_ff, seg_low_in;
   logic [POS_W-1:0]  seg_high_ff, seg_high_in;
   logic [POS_W-1:0]  k_ff, k_in;          // map build position
   logic [POS_W-1:0]  i_ff, i_in;          // emit position
   logic              done_a_ff, done_a_in;
   logic              done_b_ff, done_b_in;
   logic [TOWN_W-1:0] res_a_ff, res_a_in;
   logic [TOWN_W-1:0] res_b_ff, res_b_in;
   logic              err_a_ff, err_a_in;
   logic              err_b_ff, err_b_in;

   logic req_accept;
   logic last_item;
   logic in_seg;
   logic is_last;
   logic rsp_free;
   logic rsp_load;

   chain_cmd_type cmd_a, cmd_b;
   chain_sts_type sts_a, sts_b;

   assign req_chan.ready = (state_ff == S_LOAD);
   assign req_accept     = req_chan.valid && req_chan.ready;
   // also covers a length lowered below the running count
   assign last_item      = ({1'b0, load_count_ff} + 1'b1) >= {1'b0, len_eff};
   assign in_seg         = (i_ff >= seg_low_ff) && (i_ff <= seg_high_ff);
   assign is_last        = ({1'b0, i_ff} == last_m1);

   // ---------------- output register ----------------
   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_pos_ff;
   logic [TOWN_W-1:0] rsp_a_ff;
   logic [TOWN_W-1:0] rsp_b_ff;
   logic              rsp_err_ff;
   logic              rsp_last_ff;

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      seg_low_in    = seg_low_ff;
      seg_high_in   = seg_high_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      done_a_in     = done_a_ff;
      done_b_in     = done_b_ff;
      res_a_in      = res_a_ff;
      res_b_in      = res_b_ff;
      err_a_in      = err_a_ff;
      err_b_in      = err_b_ff;
      rsp_load      = 1'b0;

      cmd_a          = '0;
      cmd_b          = '0;
      cmd_a.walk_len = len_eff;
      cmd_b.walk_len = len_eff;

      // parent stores are written on every accepted load transaction
      cmd_a.load_en   = req_accept;
      cmd_b.load_en   = req_accept;
      cmd_a.load_pos  = load_count_ff[POS_W-1:0];
      cmd_b.load_pos  = load_count_ff[POS_W-1:0];
      cmd_a.load_town = req_chan.parent_a_town;
      cmd_b.load_town = req_chan.parent_b_town;

      case (state_ff)
         S_LOAD: begin
            if (req_accept) begin
               if (last_item) begin
                  seg_low_in      = cut_lo;
                  seg_high_in     = cut_hi;
                  load_count_in   = '0;
                  k_in            = cut_hi;
                  cmd_a.map_clear = 1'b1;
                  cmd_b.map_clear = 1'b1;
                  state_in        = S_BREAD;
               end else begin
                  load_count_in = load_count_ff + 1'b1;
               end
            end
         end
         S_BREAD: begin
            cmd_a.rd_pos = k_ff;
            cmd_b.rd_pos = k_ff;
            state_in     = S_BWRITE;
         end
         S_BWRITE: begin
            // sweeping downward, so the lowest segment position wins
            cmd_a.map_en   = 1'b1;
            cmd_a.map_town = sts_b.rd_town;
            cmd_a.map_pos  = k_ff;
            cmd_b.map_en   = 1'b1;
            cmd_b.map_town = sts_a.rd_town;
            cmd_b.map_pos  = k_ff;
            if (k_ff == seg_low_ff) begin
               i_in     = '0;
               state_in = S_EREAD;
            end else begin
               k_in     = k_ff - 1'b1;
               state_in = S_BREAD;
            end
         end
         S_EREAD: begin
            cmd_a.rd_pos = i_ff;
            cmd_b.rd_pos = i_ff;
            state_in     = S_EDEC;
         end
         S_EDEC: begin
            if (in_seg) begin
               res_a_in = sts_b.rd_town;
               res_b_in = sts_a.rd_town;
               err_a_in = 1'b0;
               err_b_in = 1'b0;
               state_in = S_OUT;
            end else begin
               cmd_a.walk_start = 1'b1;
               cmd_a.walk_town  = sts_a.rd_town;
               cmd_b.walk_start = 1'b1;
               cmd_b.walk_town  = sts_b.rd_town;
               done_a_in        = 1'b0;
               done_b_in        = 1'b0;
               state_in         = S_WALK;
            end
         end
         S_WALK: begin
            if (sts_a.done) begin
               done_a_in = 1'b1;
               res_a_in  = sts_a.town;
               err_a_in  = sts_a.err;
            end
            if (sts_b.done) begin
               done_b_in = 1'b1;
               res_b_in  = sts_b.town;
               err_b_in  = sts_b.err;
            end
            if ((done_a_ff || sts_a.done) && (done_b_ff || sts_b.done)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               if (is_last) begin
                  state_in = S_LOAD;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_EREAD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tour_length_ff <= TOUR_LENGTH_RST;
         state_ff       <= S_LOAD;
         load_count_ff  <= '0;
         seg_low_ff     <= '0;
         seg_high_ff    <= '0;
         k_ff           <= '0;
         i_ff           <= '0;
         done_a_ff      <= 1'b0;
         done_b_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         tour_length_ff <= tour_length_in;
         state_ff       <= state_in;
         load_count_ff  <= load_count_in;
         seg_low_ff     <= seg_low_in;
         seg_high_ff    <= seg_high_in;
         k_ff           <= k_in;
         i_ff           <= i_in;
         done_a_ff      <= done_a_in;
         done_b_ff      <= done_b_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_a_ff <= res_a_in;
      res_b_ff <= res_b_in;
      err_a_ff <= err_a_in;
      err_b_ff <= err_b_in;
      if (rsp_load) begin
         rsp_pos_ff  <= i_ff;
         rsp_a_ff    <= res_a_ff;
         rsp_b_ff    <= res_b_ff;
         rsp_err_ff  <= err_a_ff || err_b_ff;
         rsp_last_ff <= is_last;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.child_position = rsp_pos_ff;
   assign rsp_chan.child_a_town   = rsp_a_ff;
   assign rsp_chan.child_b_town   = rsp_b_ff;
   assign rsp_chan.chain_error    = rsp_err_ff;
   assign rsp_chan.last_of_tour   = rsp_last_ff;

   // child A: keyed by parent B towns, values from parent A
   pmx_chain #(
      .MAX_TOWNS (MAX_TOWNS)
   ) u_chain_a (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_a),
      .sts   (sts_a)
   );

   // child B: keyed by parent A towns, values from parent B
   pmx_chain #(
      .MAX_TOWNS (MAX_TOWNS)
   ) u_chain_b (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_b),
      .sts   (sts_b)
   );

   `PMX_ASSERT_NEXT(a_last_load_builds, req_accept && last_item, state_ff == S_BREAD,
                    "no map build after last load")
   `PMX_ASSERT_NOW(a_seg_ordered, 1'b1, seg_low_ff <= seg_high_ff,
                   "segment bounds out of order")
   `PMX_ASSERT_NEXT(a_last_result_reloads, rsp_load && is_last, state_ff == S_LOAD,
                    "not loading after last result")

endmodule

// ===== hw/rtl/pmx_chain.sv =====
// One parent's store plus the segment map keyed by the other parent's towns,
// and the walker that follows a mapping chain. Depends on pmx_pkg and the defines.
module pmx_chain #(
   parameter int MAX_TOWNS = pmx_pkg::DEF_MAX_TOWNS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pmx_pkg::chain_cmd_type cmd,
   output pmx_pkg::chain_sts_type sts
);
   import pmx_pkg::*;

   `include "partially_mapped_crossover_top_defines.svh"

   localparam int IDX_W = (MAX_TOWNS > 1) ? $clog2(MAX_TOWNS) : 1;

   localparam logic [1:0] W_IDLE  = 2'd0;
   localparam logic [1:0] W_LOOK  = 2'd1;
   localparam logic [1:0] W_FETCH = 2'd2;

   // parent town by position, segment position by key town
   logic [TOWN_W-1:0] val_mem_ff [MAX_TOWNS];
   logic [POS_W-1:0]  map_mem_ff [TOWN_CNT];
   logic [TOWN_CNT-1:0] valid_ff, valid_in;

   logic [TOWN_W-1:0] val_rd_ff;
   logic [POS_W-1:0]  map_rd_ff;
   logic              map_vld_ff;

   logic [1:0]        w_state_ff, w_state_in;
   logic [TOWN_W-1:0] cur_ff, cur_in;
   logic [LEN_W-1:0]  steps_ff, steps_in;

   logic [IDX_W-1:0]  val_raddr;
   logic [TOWN_W-1:0] map_raddr;
   logic              done;
   logic              err;

   always_comb begin
      w_state_in = w_state_ff;
      cur_in     = cur_ff;
      steps_in   = steps_ff;
      done       = 1'b0;
      err        = 1'b0;
      val_raddr  = cmd.rd_pos[IDX_W-1:0];
      map_raddr  = cmd.walk_town;
      case (w_state_ff)
         W_IDLE: begin
            if (cmd.walk_start) begin
               cur_in     = cmd.walk_town;
               steps_in   = '0;
               w_state_in = W_LOOK;
            end
         end
         W_LOOK: begin
            if (!map_vld_ff) begin
               done       = 1'b1;
               w_state_in = W_IDLE;
            end else if (steps_ff >= cmd.walk_len) begin
               // chain still running after a full tour of replacements
               done       = 1'b1;
               err        = 1'b1;
               w_state_in = W_IDLE;
            end else begin
               val_raddr  = map_rd_ff[IDX_W-1:0];
               steps_in   = steps_ff + 1'b1;
               w_state_in = W_FETCH;
            end
         end
         W_FETCH: begin
            cur_in     = val_rd_ff;
            map_raddr  = val_rd_ff;
            w_state_in = W_LOOK;
         end
         default: begin
            w_state_in = W_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.map_clear) begin
         valid_in = '0;
      end else if (cmd.map_en) begin
         valid_in[cmd.map_town] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_state_ff <= W_IDLE;
         valid_ff   <= '0;
         steps_ff   <= '0;
      end else begin
         w_state_ff <= w_state_in;
         valid_ff   <= valid_in;
         steps_ff   <= steps_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      val_rd_ff  <= val_mem_ff[val_raddr];
      map_rd_ff  <= map_mem_ff[map_raddr];
      map_vld_ff <= valid_ff[map_raddr];
      if (cmd.load_en) begin
         val_mem_ff[cmd.load_pos[IDX_W-1:0]] <= cmd.load_town;
      end
      if (cmd.map_en) begin
         map_mem_ff[cmd.map_town] <= cmd.map_pos;
      end
   end

   assign sts.rd_town = val_rd_ff;
   assign sts.done    = done;
   assign sts.town    = cur_ff;
   assign sts.err     = err;

   `PMX_ASSERT_NOW(a_fetch_after_look, w_state_ff == W_FETCH,
                   $past(w_state_ff) == W_LOOK, "fetch without lookup")
   `PMX_ASSERT_NEXT(a_done_to_idle, done, w_state_ff == W_IDLE, "walker busy after done")
   `PMX_ASSERT_NOW(a_map_write_idle, cmd.map_en, w_state_ff == W_IDLE,
                   "map written while walking")

endmodule

// ===== bench/pmx_checker.sv =====
// Scoreboard for the crossover block: tracks tour_length, predicts both children
// of every completed tour and compares each child position as it comes out.
// Depends on pmx_pkg, pmx_req_if and pmx_rsp_if.
module pmx_checker (
   input  logic                           clock,
   input  logic                           reset,
   pmx_req_if                             req_mon,
   pmx_rsp_if                             rsp_mon,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pmx_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pmx_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                           csr_pready,
   output int                             mismatch_count,
   output int                             children_pending,
   output int                             tours_seen,
   output int                             positions_seen,
   output int                             chain_errors_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   import pmx_pkg::*;

   typedef struct packed {
      logic [POS_W-1:0]  position;
      logic [TOWN_W-1:0] a_town;
      logic [TOWN_W-1:0] b_town;
      logic              chain_error;
      logic              last_of_tour;
   } child_pos_type;

   logic [LEN_W-1:0]  tour_length_reg;
   logic [LEN_W-1:0]  loaded;
   logic [TOWN_W-1:0] store_a [TOWN_CNT];
   logic [TOWN_W-1:0] store_b [TOWN_CNT];
   child_pos_type     child_q [$];

   function automatic int active_length();
      int len;
      len = tour_length_reg;
      if (len < 2) len = 2;
      if (len > DEF_MAX_TOWNS) len = DEF_MAX_TOWNS;
      return len;
   endfunction

   // Walk the segment mapping until the town leaves the segment. Child A maps
   // B-segment towns to A-segment towns, child B the other way round.
   function automatic logic [TOWN_W-1:0] resolve_town(input logic [TOWN_W-1:0] start,
                                                      input bit for_child_a,
                                                      input int len, input int lo,
                                                      input int hi, inout bit broken);
      logic [TOWN_W-1:0] town;
      logic [TOWN_W-1:0] key;
      int steps;
      int hit;
      int k;
      bit done;
      town  = start;
      steps = 0;
      done  = 1'b0;
      while (!done) begin
         hit = -1;
         for (k = lo; k <= hi; k++) begin
            key = for_child_a ? store_b[k] : store_a[k];
            if (hit < 0 && key == town) hit = k;   // lowest position wins
         end
         if (hit < 0) begin
            done = 1'b1;
         end else if (steps >= len) begin
            broken = 1'b1;
            done   = 1'b1;
         end else begin
            town = for_child_a ? store_a[hit] : store_b[hit];
            steps++;
         end
      end
      return town;
   endfunction

   task automatic predict_load(input logic [TOWN_W-1:0] a, input logic [TOWN_W-1:0] b,
                               input logic [POS_W-1:0] c1, input logic [POS_W-1:0] c2);
      int len;
      int lo;
      int hi;
      int tmp;
      int i;
      bit broken;
      child_pos_type exp_child;
      len = active_length();
      store_a[loaded[POS_W-1:0]] = a;
      store_b[loaded[POS_W-1:0]] = b;
      if (int'(loaded) + 1 < len) begin
         loaded = loaded + 1'b1;
      end else begin
         lo = (int'(c1) > len - 1) ? len - 1 : int'(c1);
         hi = (int'(c2) > len - 1) ? len - 1 : int'(c2);
         if (lo > hi) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
         end
         loaded = '0;
         tours_seen++;
         for (i = 0; i < len; i++) begin
            broken = 1'b0;
            if (i >= lo && i <= hi) begin
               exp_child.a_town = store_b[i];
               exp_child.b_town = store_a[i];
            end else begin
               exp_child.a_town = resolve_town(store_a[i], 1'b1, len, lo, hi, broken);
               exp_child.b_town = resolve_town(store_b[i], 1'b0, len, lo, hi, broken);
            end
            exp_child.position     = i[POS_W-1:0];
            exp_child.chain_error  = broken;
            exp_child.last_of_tour = (i == len - 1);
            child_q.push_back(exp_child);
         end
      end
   endtask

   task automatic check_child();
      child_pos_type got;
      child_pos_type want;
      got.position     = rsp_mon.child_position;
      got.a_town       = rsp_mon.child_a_town;
      got.b_town       = rsp_mon.child_b_town;
      got.chain_error  = rsp_mon.chain_error;
      got.last_of_tour = rsp_mon.last_of_tour;
      if (child_q.size() == 0) begin
         mismatch_count++;
         $display("%0t: unexpected child transaction pos=%0d a=%0d b=%0d err=%0d last=%0d",
                  $time, got.position, got.a_town, got.b_town, got.chain_error,
                  got.last_of_tour);
      end else begin
         want = child_q.pop_front();
         positions_seen++;
         if (got.chain_error === 1'b1) chain_errors_seen++;
         if (got.position !== want.position || got.a_town !== want.a_town ||
             got.b_town !== want.b_town || got.chain_error !== want.chain_error ||
             got.last_of_tour !== want.last_of_tour) begin
            mismatch_count++;
            $display("%0t: child mismatch exp pos=%0d a=%0d b=%0d err=%0d last=%0d",
                     $time, want.position, want.a_town, want.b_town, want.chain_error,
                     want.last_of_tour);
            $display("%0t:                got pos=%0d a=%0d b=%0d err=%0d last=%0d",
                     $time, got.position, got.a_town, got.b_town, got.chain_error,
                     got.last_of_tour);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tour_length_reg   = TOUR_LENGTH_RST;
         loaded            = '0;
         child_q.delete();
         mismatch_count    = 0;
         tours_seen        = 0;
         positions_seen    = 0;
         chain_errors_seen = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == REG_TOUR_LENGTH)
            tour_length_reg = csr_pwdata[LEN_W-1:0];
         if (rsp_mon.valid && rsp_mon.ready) check_child();
         if (req_mon.valid && req_mon.ready)
            predict_load(req_mon.parent_a_town, req_mon.parent_b_town,
                         req_mon.cut_first, req_mon.cut_second);
      end
      children_pending = child_q.size();
   end

endmodule

// ===== bench/partially_mapped_crossover_top_tb.sv =====
// Top of the crossover testbench: clock, reset, load and register stimulus,
// result back-pressure, watchdog and verdict. Checking lives in pmx_checker.
// Depends on pmx_pkg, pmx_req_if, pmx_rsp_if, pmx_checker and the block.
module partially_mapped_crossover_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pmx_pkg::*;

   // The limit covers the longest legal quiet stretch: a 64-position segment
   // sweep, a 64-step chain and a long result stall added together.
   localparam int WATCHDOG_LIMIT = 3000;
   // Cycles allowed after the last child before the block is back in load state.
   localparam int SETTLE_CYCLES  = 16;
   localparam int RANDOM_LOADS   = 240;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int mismatch_count;
   int children_pending;
   int tours_seen;
   int positions_seen;
   int chain_errors_seen;

   // Current tour_length register value as written, before saturation.
   int cur_len;
   // Set for whole tours during which the load side never idles.
   bit req_calm;

   int quiet_cycles;
   int stall_left;
   int calm_left;
   int ready_roll;

   logic [TOWN_W-1:0] tour_a [TOWN_CNT];
   logic [TOWN_W-1:0] tour_b [TOWN_CNT];

   pmx_req_if req_chan ();
   pmx_rsp_if rsp_chan ();

   partially_mapped_crossover_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pmx_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_chan),
      .rsp_mon           (rsp_chan),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_pready        (csr_pready),
      .mismatch_count    (mismatch_count),
      .children_pending  (children_pending),
      .tours_seen        (tours_seen),
      .positions_seen    (positions_seen),
      .chain_errors_seen (chain_errors_seen)
   );

   always #5ns clock = ~clock;

   // Result back-pressure: mostly ready, short stalls often, long stalls now
   // and then, and calm stretches with no stall at all.
   always @(posedge clock) begin
      if (calm_left > 0) begin
         calm_left--;
         rsp_chan.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         ready_roll = $urandom_range(0, 99);
         if (ready_roll < 3)       calm_left  = $urandom_range(50, 300);
         else if (ready_roll < 8)  stall_left = $urandom_range(8, 40);
         else if (ready_roll < 30) stall_left = $urandom_range(1, 3);
      end
   end

   // Watchdog: any transaction or register access counts as progress.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles at %0t", quiet_cycles, $time);
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One load transaction, preceded by a random gap with valid low.
   task automatic send_load(input logic [TOWN_W-1:0] a, input logic [TOWN_W-1:0] b,
                            input logic [POS_W-1:0] c1, input logic [POS_W-1:0] c2);
      int gap;
      int roll;
      roll = $urandom_range(0, 99);
      if (req_calm || roll < 55) gap = 0;
      else if (roll < 90)        gap = $urandom_range(1, 3);
      else                       gap = $urandom_range(6, 30);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.parent_a_town <= a;
      req_chan.parent_b_town <= b;
      req_chan.cut_first     <= c1;
      req_chan.cut_second    <= c2;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Drop valid, wait until every predicted child is out, then let the block
   // settle. Pending count is read on the falling edge, clear of the update.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (children_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write of tour_length: setup cycle, then access until pready.
   task automatic program_length(input int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= REG_TOUR_LENGTH;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cur_len = value;
   endtask

   initial begin
      int random_loads;
      int eff;
      int roll;
      int kind;
      int spread;
      int k;
      int j;
      int t;
      int pool [TOWN_CNT];
      logic [POS_W-1:0] c1;
      logic [POS_W-1:0] c2;

      // Every block input known from time zero.
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.parent_a_town = '0;
      req_chan.parent_b_town = '0;
      req_chan.cut_first     = '0;
      req_chan.cut_second    = '0;
      rsp_chan.ready         = 1'b0;
      csr_psel               = 1'b0;
      csr_penable            = 1'b0;
      csr_pwrite             = 1'b0;
      csr_paddr              = '0;
      csr_pwdata             = '0;
      cur_len                = TOUR_LENGTH_RST;
      req_calm               = 1'b0;
      quiet_cycles           = 0;
      stall_left             = 0;
      calm_left              = 0;
      random_loads           = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---------------- directed part ----------------
      // Shortest tour, extreme towns; both cuts above range saturate to 1.
      program_length(2);
      send_load(6'd0, 6'd63, 6'd17, 6'd42);
      send_load(6'd63, 6'd0, 6'd63, 6'd63);
      // Cuts out of order get swapped.
      send_load(6'd5, 6'd9, 6'd0, 6'd0);
      send_load(6'd9, 6'd5, 6'd1, 6'd0);
      wait_idle();

      // Equal cuts: a segment of one position.
      program_length(3);
      send_load(6'd0, 6'd1, 6'd0, 6'd0);
      send_load(6'd1, 6'd2, 6'd0, 6'd0);
      send_load(6'd2, 6'd0, 6'd1, 6'd1);
      // Not a permutation: towns 5 and 6 map onto each other in the segment,
      // so child A's chain at position 2 never leaves it -> chain_error.
      send_load(6'd6, 6'd5, 6'd0, 6'd0);
      send_load(6'd5, 6'd6, 6'd0, 6'd0);
      send_load(6'd5, 6'd7, 6'd1, 6'd0);
      wait_idle();

      // Register below range saturates up to 2 (both zero and one).
      program_length(0);
      send_load(6'd63, 6'd62, 6'd0, 6'd0);
      send_load(6'd62, 6'd63, 6'd0, 6'd0);
      wait_idle();
      program_length(1);
      send_load(6'd31, 6'd32, 6'd0, 6'd0);
      send_load(6'd32, 6'd31, 6'd0, 6'd63);
      wait_idle();

      // Register above range saturates to 64; shrink the length mid-tour so
      // the fourth load is already the last one.
      program_length(127);
      send_load(6'd10, 6'd13, 6'd0, 6'd0);
      send_load(6'd11, 6'd12, 6'd0, 6'd0);
      send_load(6'd12, 6'd11, 6'd0, 6'd0);
      wait_idle();
      program_length(4);
      send_load(6'd13, 6'd10, 6'd2, 6'd40);
      wait_idle();

      // Duplicate town inside the segment: lowest segment position is used.
      send_load(6'd7, 6'd1, 6'd0, 6'd0);
      send_load(6'd7, 6'd2, 6'd0, 6'd0);
      send_load(6'd1, 6'd7, 6'd0, 6'd0);
      send_load(6'd2, 6'd7, 6'd0, 6'd1);
      wait_idle();

      // ---------------- random tours ----------------
      while (random_loads < RANDOM_LOADS) begin
         // Reprogram the length now and then, only with nothing in flight.
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            wait_idle();
            roll = $urandom_range(0, 99);
            if (roll < 70)      program_length($urandom_range(2, 12));
            else if (roll < 85) program_length($urandom_range(13, 63));
            else if (roll < 93) program_length(64);
            else if (roll < 96) program_length($urandom_range(0, 1));
            else                program_length($urandom_range(65, 127));
         end
         eff = cur_len;
         if (eff < 2) eff = 2;
         if (eff > DEF_MAX_TOWNS) eff = DEF_MAX_TOWNS;
         req_calm = ($urandom_range(0, 3) == 0);

         // Parent A: random towns drawn without repeats; parent B: a shuffle
         // of the same towns.
         for (k = 0; k < TOWN_CNT; k++) pool[k] = k;
         for (k = TOWN_CNT - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            t = pool[k];
            pool[k] = pool[j];
            pool[j] = t;
         end
         for (k = 0; k < eff; k++) tour_a[k] = TOWN_W'(pool[k]);
         for (k = eff - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            t = pool[k];
            pool[k] = pool[j];
            pool[j] = t;
         end
         for (k = 0; k < eff; k++) tour_b[k] = TOWN_W'(pool[k]);

         // Mostly well-formed; some tours with a duplicated town, some noise
         // (a narrow town range makes mapping cycles likely).
         kind = $urandom_range(0, 99);
         if (kind >= 88) begin
            spread = ($urandom_range(0, 1) == 1) ? 63 : 3;
            for (k = 0; k < eff; k++) begin
               tour_a[k] = TOWN_W'($urandom_range(0, spread));
               tour_b[k] = TOWN_W'($urandom_range(0, spread));
            end
         end else if (kind >= 75) begin
            tour_a[$urandom_range(0, eff - 1)] = tour_a[$urandom_range(0, eff - 1)];
            if ($urandom_range(0, 1) == 1)
               tour_b[$urandom_range(0, eff - 1)] = tour_b[$urandom_range(0, eff - 1)];
         end

         for (k = 0; k < eff; k++) begin
            if (k == eff - 1 && $urandom_range(0, 4) != 0) begin
               c1 = POS_W'($urandom_range(0, eff - 1));
               c2 = POS_W'($urandom_range(0, eff - 1));
            end else begin
               // Cuts from the whole 0-63 range on the last load; ignored cuts elsewhere.
               c1 = POS_W'($urandom_range(0, 63));
               c2 = POS_W'($urandom_range(0, 63));
            end
            send_load(tour_a[k], tour_b[k], c1, c2);
         end
         random_loads += eff;
      end

      wait_idle();
      $display("summary: %0d tours crossed, %0d child positions checked, %0d with chain_error",
               tours_seen, positions_seen, chain_errors_seen);
      $display("summary: %0d mismatches", mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
